/* rtl/core/blms_pkg.sv */
// Shared constants, opcodes, controller states and control structs for the LED matrix scanner.
`timescale 1ns / 1ps

package blms_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 8;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int COORD_W     = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_W      = 2 * COLOR_W;
  localparam int COL_SEL_W   = 4;
  localparam int ROW_IDX_W   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [7:0] SCAN_PERIOD_RST = 8'd100;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_READ      = 3'd3,
    OP_CLEAR_ALL = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_ENABLE = 1'd0,
    REG_SCAN_PERIOD = 1'd1
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_SCAN  = 1'b0,
    KIND_REPLY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN_RD,
    ST_SCAN_RED,
    ST_SCAN_GREEN
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic load_red;
    logic load_green;
    logic load_reply;
  } cmd_t;

  typedef struct packed {
    logic scan_fire;
    logic op_read;
    logic out_free;
    logic row_last;
  } status_t;

endpackage

/* rtl/core/blms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module blms_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/blms_ctrl.sv */
// Controller state machine: sequences pixel read replies and column scan bursts.
`timescale 1ns / 1ps

module blms_ctrl
  import blms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (st.scan_fire) begin
            state_next = ST_SCAN_RD;
          end else if (st.op_read) begin
            state_next = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: begin
        if (st.out_free) begin
          cmd.load_reply = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = ST_SCAN_RED;
      end
      ST_SCAN_RED: begin
        if (st.out_free) begin
          cmd.load_red = 1'b1;
          state_next   = ST_SCAN_GREEN;
        end
      end
      ST_SCAN_GREEN: begin
        if (st.out_free) begin
          cmd.load_green = 1'b1;
          state_next     = st.row_last ? ST_IDLE : ST_SCAN_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/blms_dp.sv */
// Datapath: frame store, scan timer, column pointer, row counter and output register.
`timescale 1ns / 1ps

module blms_dp
  import blms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [2:0]            opcode,
  input  logic [COORD_W-1:0]    x_coord,
  input  logic [COORD_W-1:0]    y_coord,
  input  logic [COLOR_W-1:0]    red_in,
  input  logic [COLOR_W-1:0]    green_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [COL_SEL_W-1:0]  column_select,
  output logic                  serial_bit,
  output logic                  bit_is_green,
  output logic [ROW_IDX_W-1:0]  row_index,
  output logic                  last,
  output logic [COLOR_W-1:0]    pixel_red,
  output logic [COLOR_W-1:0]    pixel_green,
  output logic                  pixel_blank
);

  logic             scan_enable;
  logic [7:0]       tick_limit;
  logic [7:0]       tick_count;
  logic [COL_W-1:0] col_ptr;
  logic [COL_W-1:0] col_ptr_next;
  logic [ROW_W-1:0] row;
  logic [CELLS-1:0] cell_vld;

  logic              in_range;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [CELL_W-1:0] rd_data;
  logic              rd_vld;
  logic              rd_inr;
  logic [CELL_W-1:0] cell_word;
  logic [7:0]        sel_wide;
  logic [7:0]        row_wide;

  assign in_range  = (x_coord < 8'(COLUMNS)) && (y_coord < 8'(ROWS));
  assign pix_addr  = ADDR_W'(ADDR_W'(x_coord) * ADDR_W'(ROWS) + ADDR_W'(y_coord));
  assign scan_addr = ADDR_W'(ADDR_W'(col_ptr) * ADDR_W'(ROWS) + ADDR_W'(row));

  assign wr_en   = cmd.accept && in_range && (opcode == OP_SET);
  assign rd_en   = cmd.scan_rd || (cmd.accept && (opcode == OP_READ));
  assign rd_addr = cmd.scan_rd ? scan_addr : pix_addr;

  blms_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pix_addr),
    .wr_data ({green_in, red_in}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Entries never written since reset or clear-all read as zero.
  assign cell_word = rd_vld ? rd_data : '0;

  assign col_ptr_next = (col_ptr == COL_W'(COLUMNS - 1)) ? '0 : col_ptr + 1'b1;

  assign st.scan_fire = (opcode == OP_TICK) && scan_enable && !(tick_count < tick_limit);
  assign st.op_read   = (opcode == OP_READ);
  assign st.out_free  = !out_valid || !out_stall;
  assign st.row_last  = (row == ROW_W'(ROWS - 1));

  assign sel_wide = 8'(COLUMNS - 1) - 8'(col_ptr);
  assign row_wide = 8'(row);

  // Cell valid bits, scan timer, column pointer, row counter and config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld    <= '0;
      scan_enable <= 1'b0;
      tick_limit  <= SCAN_PERIOD_RST;
      tick_count  <= '0;
      col_ptr     <= '0;
      row         <= '0;
    end else begin
      if (cmd.accept) begin
        unique case (opcode)
          OP_TICK: begin
            if (scan_enable) begin
              if (tick_count < tick_limit) begin
                tick_count <= tick_count + 8'd1;
              end else begin
                tick_count <= '0;
                col_ptr    <= col_ptr_next;
                row        <= '0;
              end
            end
          end
          OP_SET: begin
            if (in_range) begin
              cell_vld[pix_addr] <= 1'b1;
            end
          end
          OP_CLEAR: begin
            if (in_range) begin
              cell_vld[pix_addr] <= 1'b0;
            end
          end
          OP_CLEAR_ALL: begin
            cell_vld <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.load_green) begin
        row <= row + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCAN_ENABLE: begin
            scan_enable <= cfg_data[0];
            tick_count  <= '0;
          end
          REG_SCAN_PERIOD: begin
            tick_limit <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Side info that travels with the registered RAM read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= cmd.scan_rd ? cell_vld[scan_addr] : (in_range && cell_vld[pix_addr]);
    end
    if (cmd.accept) begin
      rd_inr <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_red || cmd.load_green || cmd.load_reply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_red || cmd.load_green) begin
      kind          <= KIND_SCAN;
      column_select <= sel_wide[COL_SEL_W-1:0];
      serial_bit    <= cmd.load_green ? (|cell_word[CELL_W-1:COLOR_W]) :
                                        (|cell_word[COLOR_W-1:0]);
      bit_is_green  <= cmd.load_green;
      row_index     <= row_wide[ROW_IDX_W-1:0];
      last          <= cmd.load_green && st.row_last;
      pixel_red     <= '0;
      pixel_green   <= '0;
      pixel_blank   <= 1'b0;
    end else if (cmd.load_reply) begin
      kind          <= KIND_REPLY;
      column_select <= '0;
      serial_bit    <= 1'b0;
      bit_is_green  <= 1'b0;
      row_index     <= '0;
      last          <= 1'b1;
      pixel_red     <= cell_word[COLOR_W-1:0];
      pixel_green   <= cell_word[CELL_W-1:COLOR_W];
      pixel_blank   <= rd_inr && (cell_word == '0);
    end
  end

endmodule

/* rtl/core/bicolor_led_matrix_scanner_top.sv */
// Top level of the red/green LED matrix frame buffer and column scanner.
`timescale 1ns / 1ps

// Frame buffer of COLUMNS x ROWS red/green pixels with a column scan engine.
// Set, clear and clear-all items produce no beat. A read item returns one
// reply beat and stalls the input until that beat is loaded. A tick that
// fires the scan timer starts a burst of 2*ROWS beats (red then green per
// row); each row takes one frame RAM read and two output loads, and the
// input stays stalled for the whole burst plus any output stall. The frame
// RAM has one read port, which sets the per-row pace. Clear-all clears the
// per-cell valid bits; no clearing pass runs after reset. Config writes are
// always taken (cfg_ready high) and must only be issued while the block is
// idle.
module bicolor_led_matrix_scanner_top
  import blms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            opcode,
  input  logic [COORD_W-1:0]    x_coord,
  input  logic [COORD_W-1:0]    y_coord,
  input  logic [COLOR_W-1:0]    red_in,
  input  logic [COLOR_W-1:0]    green_in,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [COL_SEL_W-1:0]  column_select,
  output logic                  serial_bit,
  output logic                  bit_is_green,
  output logic [ROW_IDX_W-1:0]  row_index,
  output logic                  last,
  output logic [COLOR_W-1:0]    pixel_red,
  output logic [COLOR_W-1:0]    pixel_green,
  output logic                  pixel_blank
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  blms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  blms_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (opcode),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .red_in        (red_in),
    .green_in      (green_in),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .column_select (column_select),
    .serial_bit    (serial_bit),
    .bit_is_green  (bit_is_green),
    .row_index     (row_index),
    .last          (last),
    .pixel_red     (pixel_red),
    .pixel_green   (pixel_green),
    .pixel_blank   (pixel_blank)
  );

endmodule
